// ----- sv/wcl_pkg.sv -----
package wcl_pkg;

    // Qualifier modes: the two settled levels and the two pending changes.
    typedef enum logic [1:0] {
        MODE_LOW      = 2'd0,
        MODE_HIGH     = 2'd1,
        MODE_LAG_LOW  = 2'd2,
        MODE_LAG_HIGH = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL_D,
        S_MUL_W,
        S_MUL_L,
        S_MUL_R,
        S_MUL_Q,
        S_MUL_LO,
        S_MUL_HI,
        S_LAG,
        S_QUAL
    } t_state;

    typedef enum logic [2:0] {
        CFG_A_OFFSET    = 3'd0,
        CFG_B_OFFSET    = 3'd1,
        CFG_WINDOW_BASE = 3'd2,
        CFG_LAG_KNOB    = 3'd3,
        CFG_BIPOLAR     = 3'd4,
        CFG_SAMPLE_RATE = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 31;
    localparam int PROD_W = 62;

    // floor(x / 10000) == (x * RECIP_10K) >> RECIP_SHIFT for every x below 2^31.
    localparam logic [MUL_W-1:0] RECIP_10K = 31'd1759218605;
    localparam int RECIP_SHIFT = 44;

    // Width of the lag sample count before it is saturated to the counter width.
    localparam int LAG_N_W = 20;

    localparam logic [13:0]        SCALE_FULL = 14'd10000;
    localparam logic signed [15:0] SAT_MV     = 16'sd12000;

    localparam logic signed [14:0] LEVEL_HI_UNI = 15'sd10000;
    localparam logic signed [14:0] LEVEL_LO_UNI = 15'sd0;
    localparam logic signed [14:0] LEVEL_HI_BI  = 15'sd5000;
    localparam logic signed [14:0] LEVEL_LO_BI  = -15'sd5000;

    localparam logic [14:0] RST_WINDOW_BASE = 15'd5000;
    localparam logic [16:0] RST_LAG_KNOB    = 17'd6554;
    localparam logic [17:0] RST_SAMPLE_RATE = 18'd44100;

endpackage

// ----- sv/wcl_in_if.sv -----
interface wcl_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] a_cv_mv;
    logic               a_cv_present;
    logic signed [14:0] b_cv_mv;
    logic               b_cv_present;
    logic signed [14:0] window_cv_mv;
    logic               window_cv_present;
    logic signed [14:0] lag_cv_mv;
    logic               lag_cv_present;

    modport source (
        output valid, a_cv_mv, a_cv_present, b_cv_mv, b_cv_present,
               window_cv_mv, window_cv_present, lag_cv_mv, lag_cv_present,
        input  ready
    );

    modport sink (
        input  valid, a_cv_mv, a_cv_present, b_cv_mv, b_cv_present,
               window_cv_mv, window_cv_present, lag_cv_mv, lag_cv_present,
        output ready
    );
endinterface

// ----- sv/wcl_out_if.sv -----
interface wcl_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] greater_level_mv;
    logic signed [14:0] less_level_mv;
    logic signed [14:0] equal_level_mv;
    logic signed [14:0] not_equal_level_mv;

    modport source (
        output valid, greater_level_mv, less_level_mv, equal_level_mv,
               not_equal_level_mv,
        input  ready
    );

    modport sink (
        input  valid, greater_level_mv, less_level_mv, equal_level_mv,
               not_equal_level_mv,
        output ready
    );
endinterface

// ----- sv/wcl_qualify.sv -----
module wcl_qualify #(
    parameter int COUNT_BITS = 18
) (
    input  wcl_pkg::t_mode         i_mode,
    input  logic [COUNT_BITS-1:0]  i_cnt,
    input  logic                   i_hi,
    input  logic [COUNT_BITS-1:0]  i_lag,
    output wcl_pkg::t_mode         o_mode,
    output logic [COUNT_BITS-1:0]  o_cnt
);

    logic [COUNT_BITS-1:0] w_dec;
    logic                  w_no_lag;

    // The countdown wraps when it is decremented from zero.
    assign w_dec    = i_cnt - COUNT_BITS'(1);
    assign w_no_lag = (i_lag == '0);

    always_comb begin
        o_mode = i_mode;
        o_cnt  = i_cnt;
        unique case (i_mode)
            wcl_pkg::MODE_LOW: begin
                if (i_hi) begin
                    if (w_no_lag) begin
                        o_mode = wcl_pkg::MODE_HIGH;
                    end else begin
                        o_mode = wcl_pkg::MODE_LAG_HIGH;
                        o_cnt  = i_lag;
                    end
                end
            end
            wcl_pkg::MODE_HIGH: begin
                if (!i_hi) begin
                    if (w_no_lag) begin
                        o_mode = wcl_pkg::MODE_LOW;
                    end else begin
                        o_mode = wcl_pkg::MODE_LAG_LOW;
                        o_cnt  = i_lag;
                    end
                end
            end
            wcl_pkg::MODE_LAG_LOW: begin
                if (!i_hi) begin
                    o_cnt = w_dec;
                    if (w_dec == '0) o_mode = wcl_pkg::MODE_LOW;
                end else begin
                    o_mode = wcl_pkg::MODE_HIGH;
                end
            end
            wcl_pkg::MODE_LAG_HIGH: begin
                if (i_hi) begin
                    o_cnt = w_dec;
                    if (w_dec == '0) o_mode = wcl_pkg::MODE_HIGH;
                end else begin
                    o_mode = wcl_pkg::MODE_LOW;
                end
            end
            default: begin
                o_mode = i_mode;
            end
        endcase
    end

endmodule

// ----- sv/window_comparator_with_lag.sv -----
// Channel   Dir  Handshake              Payload
// i_in      in   i_in.valid/ready       A, B, window and lag CV samples with present flags
// o_out     out  o_out.valid/ready      greater, less, equal, not-equal levels in mV
// i_cfg_*   in   i_cfg_we               register index and data, no read-back
//
// Each request runs the sequencer: one 31x31 multiplier is reused over seven steps
// (window product, window bound, lag scaling, divide by 10000, lag squared and
// two partial products with the sample rate), then the qualifiers update.
// Reset is synchronous and active low; it restores register defaults and LOW modes.
// The result sits in an output register; a new request is taken while it waits.
// If the output is still full at the final step, the sequencer holds there.
module window_comparator_with_lag #(
    parameter int COUNT_BITS = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wcl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wcl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    wcl_in_if.sink                              i_in,
    wcl_out_if.source                           o_out
);

    // Configuration registers.
    logic signed [14:0] r_a_off;
    logic signed [14:0] r_b_off;
    logic [13:0]        r_win_base;
    logic [16:0]        r_lag_knob;
    logic               r_bipolar;
    logic [17:0]        r_fs;

    // Sequencer and datapath registers.
    wcl_pkg::t_state            r_state;
    wcl_pkg::t_state            n_state;
    logic signed [15:0]         r_a;
    logic signed [15:0]         r_b;
    logic [13:0]                r_wc;
    logic [13:0]                r_lc;
    logic                       r_win_present;
    logic                       r_lag_present;
    logic [15:0]                r_d;
    logic                       r_ge;
    logic [28:0]                r_lhs;
    logic                       r_win;
    logic [16:0]                r_hi;
    logic [34:0]                r_acc;
    logic [wcl_pkg::LAG_N_W-1:0] r_n;
    logic [wcl_pkg::PROD_W-1:0] r_prod;

    wcl_pkg::t_mode             r_thr_mode;
    logic [COUNT_BITS-1:0]      r_thr_cnt;
    wcl_pkg::t_mode             r_win_mode;
    logic [COUNT_BITS-1:0]      r_win_cnt;

    logic                       r_out_valid;
    logic signed [14:0]         r_greater;
    logic signed [14:0]         r_less;
    logic signed [14:0]         r_equal;
    logic signed [14:0]         r_not_equal;

    // Combinational signals.
    logic                       w_accept;
    logic                       w_load;
    logic [wcl_pkg::MUL_W-1:0]  w_mul_a;
    logic [wcl_pkg::MUL_W-1:0]  w_mul_b;
    logic signed [15:0]         w_a_sum;
    logic signed [15:0]         w_b_sum;
    logic signed [16:0]         w_diff;
    logic signed [16:0]         w_diff_abs;
    logic [16:0]                w_lq;
    logic [51:0]                w_lag_sum;
    logic [COUNT_BITS-1:0]      w_lag;
    wcl_pkg::t_mode             w_thr_mode;
    logic [COUNT_BITS-1:0]      w_thr_cnt;
    wcl_pkg::t_mode             w_win_mode;
    logic [COUNT_BITS-1:0]      w_win_cnt;
    logic signed [14:0]         w_hv;
    logic signed [14:0]         w_lv;
    logic                       w_thr_high;
    logic                       w_win_high;

    function automatic logic signed [15:0] sat_mv(input logic signed [15:0] v);
        logic signed [15:0] res;
        if (v > wcl_pkg::SAT_MV) begin
            res = wcl_pkg::SAT_MV;
        end else if (v < -wcl_pkg::SAT_MV) begin
            res = -wcl_pkg::SAT_MV;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [13:0] clamp_scale(input logic signed [14:0] v);
        logic [13:0] res;
        if (v[14]) begin
            res = '0;
        end else if (v[13:0] > wcl_pkg::SCALE_FULL) begin
            res = wcl_pkg::SCALE_FULL;
        end else begin
            res = v[13:0];
        end
        return res;
    endfunction

    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == wcl_pkg::S_QUAL) && (!r_out_valid || o_out.ready);

    assign w_a_sum    = {r_a_off[14], r_a_off} + {i_in.a_cv_mv[14], i_in.a_cv_mv};
    assign w_b_sum    = {r_b_off[14], r_b_off} + {i_in.b_cv_mv[14], i_in.b_cv_mv};
    assign w_diff     = {r_a[15], r_a} - {r_b[15], r_b};
    assign w_diff_abs = w_diff[16] ? -w_diff : w_diff;

    // Scaled lag in Q1.16: the quotient by 10000 comes out of the reciprocal product.
    assign w_lq = r_lag_present ? r_prod[wcl_pkg::RECIP_SHIFT+16:wcl_pkg::RECIP_SHIFT]
                                : r_lag_knob;

    assign w_lag_sum = {r_prod[34:0], 17'd0} + {17'd0, r_acc};

    generate
        if (COUNT_BITS >= wcl_pkg::LAG_N_W) begin : g_lag_wide
            assign w_lag = COUNT_BITS'(r_n);
        end else begin : g_lag_sat
            assign w_lag = (|r_n[wcl_pkg::LAG_N_W-1:COUNT_BITS]) ? '1
                                                                  : r_n[COUNT_BITS-1:0];
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wcl_pkg::S_IDLE:   if (w_accept) n_state = wcl_pkg::S_DIFF;
            wcl_pkg::S_DIFF:   n_state = wcl_pkg::S_MUL_D;
            wcl_pkg::S_MUL_D:  n_state = wcl_pkg::S_MUL_W;
            wcl_pkg::S_MUL_W:  n_state = wcl_pkg::S_MUL_L;
            wcl_pkg::S_MUL_L:  n_state = wcl_pkg::S_MUL_R;
            wcl_pkg::S_MUL_R:  n_state = wcl_pkg::S_MUL_Q;
            wcl_pkg::S_MUL_Q:  n_state = wcl_pkg::S_MUL_LO;
            wcl_pkg::S_MUL_LO: n_state = wcl_pkg::S_MUL_HI;
            wcl_pkg::S_MUL_HI: n_state = wcl_pkg::S_LAG;
            wcl_pkg::S_LAG:    n_state = wcl_pkg::S_QUAL;
            wcl_pkg::S_QUAL:   if (w_load) n_state = wcl_pkg::S_IDLE;
            default:           n_state = wcl_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand select.
    always_comb begin
        i_in.ready = (r_state == wcl_pkg::S_IDLE);
        w_mul_a    = '0;
        w_mul_b    = '0;
        unique case (r_state)
            wcl_pkg::S_MUL_D: begin
                w_mul_a = wcl_pkg::MUL_W'(r_d);
                w_mul_b = wcl_pkg::MUL_W'(wcl_pkg::SCALE_FULL);
            end
            wcl_pkg::S_MUL_W: begin
                w_mul_a = wcl_pkg::MUL_W'(r_win_base);
                w_mul_b = wcl_pkg::MUL_W'(r_wc);
            end
            wcl_pkg::S_MUL_L: begin
                w_mul_a = wcl_pkg::MUL_W'(r_lag_knob);
                w_mul_b = wcl_pkg::MUL_W'(r_lc);
            end
            wcl_pkg::S_MUL_R: begin
                w_mul_a = r_prod[wcl_pkg::MUL_W-1:0];
                w_mul_b = wcl_pkg::RECIP_10K;
            end
            wcl_pkg::S_MUL_Q: begin
                w_mul_a = wcl_pkg::MUL_W'(w_lq);
                w_mul_b = wcl_pkg::MUL_W'(w_lq);
            end
            wcl_pkg::S_MUL_LO: begin
                w_mul_a = wcl_pkg::MUL_W'(r_prod[16:0]);
                w_mul_b = wcl_pkg::MUL_W'(r_fs);
            end
            wcl_pkg::S_MUL_HI: begin
                w_mul_a = wcl_pkg::MUL_W'(r_hi);
                w_mul_b = wcl_pkg::MUL_W'(r_fs);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    wcl_qualify #(.COUNT_BITS(COUNT_BITS)) u_thr_qual (
        .i_mode (r_thr_mode),
        .i_cnt  (r_thr_cnt),
        .i_hi   (r_ge),
        .i_lag  (w_lag),
        .o_mode (w_thr_mode),
        .o_cnt  (w_thr_cnt)
    );

    wcl_qualify #(.COUNT_BITS(COUNT_BITS)) u_win_qual (
        .i_mode (r_win_mode),
        .i_cnt  (r_win_cnt),
        .i_hi   (r_win),
        .i_lag  (w_lag),
        .o_mode (w_win_mode),
        .o_cnt  (w_win_cnt)
    );

    assign w_hv       = r_bipolar ? wcl_pkg::LEVEL_HI_BI : wcl_pkg::LEVEL_HI_UNI;
    assign w_lv       = r_bipolar ? wcl_pkg::LEVEL_LO_BI : wcl_pkg::LEVEL_LO_UNI;
    assign w_thr_high = (w_thr_mode == wcl_pkg::MODE_HIGH) ||
                        (w_thr_mode == wcl_pkg::MODE_LAG_LOW);
    assign w_win_high = (w_win_mode == wcl_pkg::MODE_HIGH) ||
                        (w_win_mode == wcl_pkg::MODE_LAG_LOW);

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wcl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_thr_mode  <= wcl_pkg::MODE_LOW;
            r_thr_cnt   <= '0;
            r_win_mode  <= wcl_pkg::MODE_LOW;
            r_win_cnt   <= '0;
            r_a_off     <= '0;
            r_b_off     <= '0;
            r_win_base  <= wcl_pkg::RST_WINDOW_BASE[13:0];
            r_lag_knob  <= wcl_pkg::RST_LAG_KNOB;
            r_bipolar   <= 1'b0;
            r_fs        <= wcl_pkg::RST_SAMPLE_RATE;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_thr_mode  <= w_thr_mode;
                r_thr_cnt   <= w_thr_cnt;
                r_win_mode  <= w_win_mode;
                r_win_cnt   <= w_win_cnt;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wcl_pkg::CFG_A_OFFSET:    r_a_off    <= i_cfg_data[14:0];
                    wcl_pkg::CFG_B_OFFSET:    r_b_off    <= i_cfg_data[14:0];
                    wcl_pkg::CFG_WINDOW_BASE: r_win_base <= i_cfg_data[13:0];
                    wcl_pkg::CFG_LAG_KNOB:    r_lag_knob <= i_cfg_data[16:0];
                    wcl_pkg::CFG_BIPOLAR:     r_bipolar  <= i_cfg_data[0];
                    wcl_pkg::CFG_SAMPLE_RATE: r_fs       <= i_cfg_data[17:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath. The product register follows the shared multiplier every cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= wcl_pkg::PROD_W'(w_mul_a) * wcl_pkg::PROD_W'(w_mul_b);
        unique case (r_state)
            wcl_pkg::S_IDLE: begin
                if (w_accept) begin
                    // Without its CV an input is the offset alone, with no saturation.
                    r_a <= i_in.a_cv_present ? sat_mv(w_a_sum) : {r_a_off[14], r_a_off};
                    r_b <= i_in.b_cv_present ? sat_mv(w_b_sum) : {r_b_off[14], r_b_off};
                    r_wc          <= clamp_scale(i_in.window_cv_mv);
                    r_lc          <= clamp_scale(i_in.lag_cv_mv);
                    r_win_present <= i_in.window_cv_present;
                    r_lag_present <= i_in.lag_cv_present;
                end
            end
            wcl_pkg::S_DIFF: begin
                r_ge <= !w_diff[16];
                r_d  <= w_diff_abs[15:0];
            end
            wcl_pkg::S_MUL_W: begin
                r_lhs <= r_prod[28:0];
            end
            wcl_pkg::S_MUL_L: begin
                if (r_win_present) begin
                    r_win <= (r_lhs <= {1'b0, r_prod[27:0]});
                end else begin
                    r_win <= (r_d <= {2'b00, r_win_base});
                end
            end
            wcl_pkg::S_MUL_LO: begin
                r_hi <= r_prod[33:17];
            end
            wcl_pkg::S_MUL_HI: begin
                r_acc <= r_prod[34:0];
            end
            wcl_pkg::S_LAG: begin
                r_n <= w_lag_sum[51:32];
            end
            wcl_pkg::S_QUAL: begin
                if (w_load) begin
                    r_greater   <= w_thr_high ? w_hv : w_lv;
                    r_less      <= w_thr_high ? w_lv : w_hv;
                    r_equal     <= w_win_high ? w_hv : w_lv;
                    r_not_equal <= w_win_high ? w_lv : w_hv;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.greater_level_mv   = r_greater;
    assign o_out.less_level_mv      = r_less;
    assign o_out.equal_level_mv     = r_equal;
    assign o_out.not_equal_level_mv = r_not_equal;

endmodule
